### design/bsv_pkg.sv
`default_nettype none

package bsv_pkg;

  localparam int VOICE_COUNT_DEF = 8;

  // field widths
  localparam int OP_W    = 2;
  localparam int ID_W    = 32;
  localparam int VEL_W   = 17;
  localparam int INC_W   = 31;
  localparam int HARM_W  = 12;
  localparam int PHASE_W = 32;
  localparam int INTEG_W = 48;
  localparam int VALUE_W = 24;
  localparam int GAIN_W  = 19;
  localparam int LEAK_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SINE_W  = 18;

  // operation codes
  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd2;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPULSE_GAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK        = 2'd3;

  localparam logic signed [GAIN_W-1:0] FIRST_GAIN_RESET   = -19'sd80263;
  localparam logic signed [GAIN_W-1:0] SECOND_GAIN_RESET  = 19'sd6897;
  localparam logic signed [GAIN_W-1:0] IMPULSE_GAIN_RESET = 19'sd38522;
  localparam logic [LEAK_W-1:0]        LEAK_RESET         = 16'd65208;

  // quarter-wave polynomial
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [16:0] SIN_B = 17'd42631;
  localparam logic [12:0] SIN_C = 13'd5223;

  localparam logic [PHASE_W-1:0] PHASE_START = 32'h8000_0000;

  typedef struct packed {
    logic signed [ID_W-1:0]    note_id;
    logic [VEL_W-1:0]          velocity;
    logic [PHASE_W-1:0]        phase;
    logic [INC_W-1:0]          increment;
    logic [HARM_W-1:0]         harmonics;
    logic signed [INTEG_W-1:0] integrator;
    logic signed [VALUE_W-1:0] value;
  } voice_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_OFF_RD,
    ST_OFF_CMP,
    ST_T_RD,
    ST_T_LOAD,
    ST_T_MIX,
    ST_T_S1,
    ST_T_S2,
    ST_T_DEN,
    ST_T_NUM,
    ST_T_DIV,
    ST_T_STEP,
    ST_T_LEAK,
    ST_T_ACC,
    ST_T_GI,
    ST_T_VAL,
    ST_T_WB,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

### design/bsv_in_if.sv
`default_nettype none

interface bsv_in_if;
  logic                                valid;
  logic                                ready;
  logic [bsv_pkg::OP_W-1:0]            operation;
  logic signed [bsv_pkg::ID_W-1:0]     note_id;
  logic [bsv_pkg::VEL_W-1:0]           velocity;
  logic [bsv_pkg::INC_W-1:0]           phase_increment;
  logic [bsv_pkg::HARM_W-1:0]          harmonic_count;

  modport source (output valid, operation, note_id, velocity, phase_increment,
                  harmonic_count, input ready);
  modport sink (input valid, operation, note_id, velocity, phase_increment,
                harmonic_count, output ready);
endinterface

`default_nettype wire

### design/bsv_out_if.sv
`default_nettype none

interface bsv_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bsv_pkg::VALUE_W-1:0]   sample;
  logic                                 all_silent;

  modport source (output valid, sample, all_silent, input ready);
  modport sink (input valid, sample, all_silent, output ready);
endinterface

`default_nettype wire

### design/blit_hardsync_sine_voice_bank.sv
`default_nettype none
// note on: writes the free voice on accept; note off: reads and compares voices in turn
// tick: per voice with 3 or more harmonics, four sines and a radix-2 divider,
//   no divider on a zero divisor, two sines with 2, one sine with fewer; then the
//   result register is loaded; voices serially
// one item at a time; the result register frees the input while a sample waits
// reset (rst, synchronous): voices inactive and read as zero, gains to defaults

module blit_hardsync_sine_voice_bank #(
  parameter int VOICE_COUNT = bsv_pkg::VOICE_COUNT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  bsv_in_if.sink                                  note_in,
  bsv_out_if.source                               sample_out,
  input  wire logic                               cfg_we,
  input  wire logic [bsv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bsv_pkg::GAIN_W-1:0]         cfg_data
);

  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [VW:0] LAST = (VW+1)'(VOICE_COUNT - 1);

  // configuration registers
  logic signed [bsv_pkg::GAIN_W-1:0] first_gain;
  logic signed [bsv_pkg::GAIN_W-1:0] second_gain;
  logic signed [bsv_pkg::GAIN_W-1:0] impulse_gain;
  logic [bsv_pkg::LEAK_W-1:0]        leak;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_gain   <= bsv_pkg::FIRST_GAIN_RESET;
      second_gain  <= bsv_pkg::SECOND_GAIN_RESET;
      impulse_gain <= bsv_pkg::IMPULSE_GAIN_RESET;
      leak         <= bsv_pkg::LEAK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bsv_pkg::CFG_FIRST_GAIN:   first_gain   <= cfg_data;
        bsv_pkg::CFG_SECOND_GAIN:  second_gain  <= cfg_data;
        bsv_pkg::CFG_IMPULSE_GAIN: impulse_gain <= cfg_data;
        bsv_pkg::CFG_LEAK:         leak         <= cfg_data[bsv_pkg::LEAK_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  bsv_pkg::state_t state, state_next;
  logic [VW:0]            kcnt;
  logic [VOICE_COUNT-1:0] active;
  logic [VOICE_COUNT-1:0] written;   // entry holds data, else reads as zero
  logic                   out_valid;

  // voice memory, one entry per voice
  bsv_pkg::voice_t mem [VOICE_COUNT];
  bsv_pkg::voice_t rd_data;
  logic            rd_written;
  logic            mem_re;
  logic            mem_we;
  logic [VW-1:0]   wr_addr;
  bsv_pkg::voice_t wr_data;

  // per-voice working registers
  bsv_pkg::voice_t cur;
  logic                              cur_act;
  logic signed [bsv_pkg::ID_W-1:0]   off_id;
  logic signed [41:0]                mixprod;
  logic signed [47:0]                mix;
  logic [bsv_pkg::PHASE_W-1:0]       preg;
  logic [bsv_pkg::PHASE_W-1:0]       harg;
  logic signed [20:0]                g1t;
  logic signed [20:0]                g2t;
  logic signed [42:0]                git;
  logic signed [bsv_pkg::SINE_W-1:0] den;
  logic signed [31:0]                bq;
  logic signed [63:0]                stepprod;
  logic signed [64:0]                leakprod;
  logic signed [47:0]                inew;
  logic signed [23:0]                vnew;
  logic signed [23:0]                sample_q;
  logic                              silent_q;

  // sine unit
  logic                              sin_start;
  logic [bsv_pkg::PHASE_W-1:0]       sin_arg;
  logic [2:0]                        scnt;
  logic                              sdone;
  logic [16:0]                       sz;
  logic [16:0]                       sz2;
  logic [16:0]                       st;
  logic                              sneg;
  logic signed [bsv_pkg::SINE_W-1:0] sres;

  // divider
  logic        div_start;
  logic [5:0]  dcnt;
  logic        ddone;
  logic [33:0] dq;
  logic [17:0] drem;
  logic [16:0] dd;
  logic        dneg;

  logic            in_acc;
  logic            free_found;
  logic [VW-1:0]   free_idx;
  logic [VW-1:0]   kidx;
  logic            last_k;
  logic            n2;
  logic            n3;
  logic            id_match;
  logic            out_load;
  bsv_pkg::voice_t rd_v;
  logic [bsv_pkg::PHASE_W-1:0] p_c;
  logic signed [32:0]          hs;
  logic [bsv_pkg::PHASE_W-1:0] half;
  logic [bsv_pkg::PHASE_W-1:0] np_lo;
  logic [29:0]                 lim;

  assign in_acc   = note_in.valid && note_in.ready;
  assign kidx     = kcnt[VW-1:0];
  assign last_k   = (kcnt == LAST);
  assign n2       = (cur.harmonics >= 12'd2);
  assign n3       = (cur.harmonics >= 12'd3);
  assign rd_v     = rd_written ? rd_data : '0;
  assign id_match = (rd_v.note_id == off_id);
  assign out_load = (state == bsv_pkg::ST_EMIT) && (!out_valid || sample_out.ready);

  // advanced phase and the half phase, truncated toward zero as signed
  assign p_c   = cur.phase + {1'b0, cur.increment};
  assign hs    = $signed({preg[31], preg}) + $signed({32'd0, preg[31]});
  assign half  = hs[32:1];
  assign np_lo = preg * {20'd0, cur.harmonics};
  // clamp of the impulse ratio, 2*(2n+1) in Q16
  assign lim   = {cur.harmonics, 1'b1, 17'd0};

  // lowest free voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = VOICE_COUNT - 1; k >= 0; k--) begin
      if (!active[k]) begin
        free_found = 1'b1;
        free_idx   = VW'(k);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bsv_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (note_in.operation)
            bsv_pkg::OP_NOTE_OFF: state_next = bsv_pkg::ST_OFF_RD;
            bsv_pkg::OP_TICK:     state_next = bsv_pkg::ST_T_RD;
            default:              state_next = bsv_pkg::ST_IDLE;
          endcase
        end
      end
      bsv_pkg::ST_OFF_RD:  state_next = bsv_pkg::ST_OFF_CMP;
      bsv_pkg::ST_OFF_CMP: begin
        state_next = (id_match || last_k) ? bsv_pkg::ST_IDLE : bsv_pkg::ST_OFF_RD;
      end
      bsv_pkg::ST_T_RD:   state_next = bsv_pkg::ST_T_LOAD;
      bsv_pkg::ST_T_LOAD: state_next = bsv_pkg::ST_T_MIX;
      bsv_pkg::ST_T_MIX:  state_next = bsv_pkg::ST_T_S1;
      bsv_pkg::ST_T_S1: begin
        if (sdone) state_next = n2 ? bsv_pkg::ST_T_S2 : bsv_pkg::ST_T_VAL;
      end
      bsv_pkg::ST_T_S2: begin
        if (sdone) state_next = n3 ? bsv_pkg::ST_T_DEN : bsv_pkg::ST_T_VAL;
      end
      bsv_pkg::ST_T_DEN: begin
        if (sdone) state_next = bsv_pkg::ST_T_NUM;
      end
      bsv_pkg::ST_T_NUM: begin
        if (sdone) state_next = (den == '0) ? bsv_pkg::ST_T_STEP : bsv_pkg::ST_T_DIV;
      end
      bsv_pkg::ST_T_DIV: begin
        if (ddone) state_next = bsv_pkg::ST_T_STEP;
      end
      bsv_pkg::ST_T_STEP: state_next = bsv_pkg::ST_T_LEAK;
      bsv_pkg::ST_T_LEAK: state_next = bsv_pkg::ST_T_ACC;
      bsv_pkg::ST_T_ACC:  state_next = bsv_pkg::ST_T_GI;
      bsv_pkg::ST_T_GI:   state_next = bsv_pkg::ST_T_VAL;
      bsv_pkg::ST_T_VAL:  state_next = bsv_pkg::ST_T_WB;
      bsv_pkg::ST_T_WB:   state_next = last_k ? bsv_pkg::ST_EMIT : bsv_pkg::ST_T_RD;
      bsv_pkg::ST_EMIT: begin
        if (out_load) state_next = bsv_pkg::ST_IDLE;
      end
      default: state_next = bsv_pkg::ST_IDLE;
    endcase
  end

  // state outputs: memory port, unit starts
  always_comb begin
    note_in.ready = (state == bsv_pkg::ST_IDLE);
    mem_re    = (state == bsv_pkg::ST_OFF_RD) || (state == bsv_pkg::ST_T_RD);
    mem_we    = 1'b0;
    wr_addr   = kidx;
    wr_data   = cur;
    sin_start = 1'b0;
    sin_arg   = p_c;
    div_start = 1'b0;
    case (state)
      bsv_pkg::ST_IDLE: begin
        // a note-on loads every field of the free voice at once
        wr_addr            = free_idx;
        wr_data.note_id    = note_in.note_id;
        wr_data.velocity   = note_in.velocity;
        wr_data.phase      = bsv_pkg::PHASE_START;
        wr_data.increment  = note_in.phase_increment;
        wr_data.harmonics  = note_in.harmonic_count;
        wr_data.integrator = '0;
        wr_data.value      = '0;
        mem_we = in_acc && (note_in.operation == bsv_pkg::OP_NOTE_ON) && free_found;
      end
      bsv_pkg::ST_T_MIX: begin
        sin_start = 1'b1;
        sin_arg   = p_c;
      end
      bsv_pkg::ST_T_S1: begin
        sin_start = sdone && n2;
        sin_arg   = {preg[30:0], 1'b0};
      end
      bsv_pkg::ST_T_S2: begin
        sin_start = sdone && n3;
        sin_arg   = half;
      end
      bsv_pkg::ST_T_DEN: begin
        sin_start = sdone;
        sin_arg   = harg;
      end
      bsv_pkg::ST_T_NUM: begin
        div_start = sdone && (den != '0);
      end
      bsv_pkg::ST_T_WB: begin
        mem_we             = 1'b1;
        wr_addr            = kidx;
        wr_data            = cur;
        wr_data.phase      = preg;
        wr_data.integrator = inew;
        wr_data.value      = vnew;
      end
      default: ;
    endcase
  end

  // memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) begin
      rd_data    <= mem[kidx];
      rd_written <= written[kidx];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bsv_pkg::ST_IDLE;
      kcnt      <= '0;
      active    <= '0;
      written   <= '0;
      out_valid <= 1'b0;
      scnt      <= '0;
      sdone     <= 1'b0;
      dcnt      <= '0;
      ddone     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bsv_pkg::ST_IDLE) begin
        kcnt <= '0;
      end else if ((state == bsv_pkg::ST_OFF_CMP) || (state == bsv_pkg::ST_T_WB)) begin
        kcnt <= kcnt + 1'b1;
      end
      if (mem_we) written[wr_addr] <= 1'b1;
      if ((state == bsv_pkg::ST_IDLE) && mem_we) active[free_idx] <= 1'b1;
      if ((state == bsv_pkg::ST_OFF_CMP) && id_match) active[kidx] <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (sample_out.ready) begin
        out_valid <= 1'b0;
      end
      // sine unit sequence: load, then four multiply steps
      sdone <= 1'b0;
      if (sin_start) begin
        scnt <= 3'd1;
      end else if (scnt == 3'd4) begin
        scnt  <= 3'd0;
        sdone <= 1'b1;
      end else if (scnt != 3'd0) begin
        scnt <= scnt + 3'd1;
      end
      // divider: one quotient bit per cycle
      ddone <= 1'b0;
      if (div_start) begin
        dcnt <= 6'd1;
      end else if (dcnt == 6'd34) begin
        dcnt  <= 6'd0;
        ddone <= 1'b1;
      end else if (dcnt != 6'd0) begin
        dcnt <= dcnt + 6'd1;
      end
    end
  end

  // sine datapath
  logic [30:0] xin;
  logic [33:0] sq;
  logic [29:0] cz;
  logic [33:0] tz;
  logic [33:0] rz;
  logic [17:0] rmag;

  always_comb begin
    xin  = sin_arg[30] ? (31'h4000_0000 - {1'b0, sin_arg[29:0]}) : {1'b0, sin_arg[29:0]};
    sq   = {17'd0, sz} * {17'd0, sz};
    cz   = {17'd0, bsv_pkg::SIN_C} * {13'd0, sz2};
    tz   = {17'd0, st} * {17'd0, sz2};
    rz   = {17'd0, st} * {17'd0, sz};
    rmag = {1'b0, rz[32:16]};
  end

  always_ff @(posedge clk) begin
    if (sin_start) begin
      sz   <= xin[30:14];
      sneg <= sin_arg[31];
    end
    case (scnt)
      3'd1: sz2 <= sq[32:16];
      3'd2: st  <= bsv_pkg::SIN_B - {3'd0, cz[29:16]};
      3'd3: st  <= bsv_pkg::SIN_A - tz[32:16];
      3'd4: sres <= sneg ? -$signed(rmag) : $signed(rmag);
      default: ;
    endcase
  end

  // divider datapath, magnitudes with the sign kept aside
  logic [17:0] nabs18;
  logic [17:0] dabs18;
  logic [17:0] dshift;
  logic        dge;

  always_comb begin
    nabs18 = sres[17] ? 18'(-sres) : sres;
    dabs18 = den[17] ? 18'(-den) : den;
    dshift = {drem[16:0], dq[33]};
    dge    = (dshift >= {1'b0, dd});
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      dq   <= {nabs18[16:0], 17'd0};
      drem <= '0;
      dd   <= dabs18[16:0];
      dneg <= sres[17] ^ den[17];
    end else if (dcnt != 6'd0) begin
      drem <= dge ? (dshift - {1'b0, dd}) : dshift;
      dq   <= {dq[32:0], dge};
    end
  end

  // voice arithmetic
  logic signed [36:0] g1prod;
  logic signed [36:0] g2prod;
  logic signed [58:0] giprod;
  logic signed [35:0] qs;
  logic signed [35:0] lims;
  logic signed [35:0] qclamp;
  logic signed [35:0] bwide;
  logic signed [49:0] acc;
  logic signed [44:0] vsum;
  logic signed [31:0] mix32;

  always_comb begin
    g1prod = first_gain * sres;
    g2prod = second_gain * sres;
    giprod = impulse_gain * $signed(inew[47:8]);
    qs     = dneg ? -$signed({2'b00, dq}) : $signed({2'b00, dq});
    lims   = $signed({6'd0, lim});
    if (qs > lims) begin
      qclamp = lims;
    end else if (qs < -lims) begin
      qclamp = -lims;
    end else begin
      qclamp = qs;
    end
    bwide  = qclamp - 36'sd131072;
    acc    = $signed(leakprod[64:16]) + $signed(stepprod[63:24]);
    vsum   = g1t + g2t + git;
    mix32  = mix[47:16];
  end

  always_ff @(posedge clk) begin
    if (in_acc) off_id <= note_in.note_id;
    if (in_acc && (note_in.operation == bsv_pkg::OP_TICK)) mix <= '0;
    case (state)
      bsv_pkg::ST_T_LOAD: begin
        cur     <= rd_v;
        cur_act <= active[kidx];
        mixprod <= rd_v.value * $signed({1'b0, rd_v.velocity});
      end
      bsv_pkg::ST_T_MIX: begin
        // mix uses the value stored before this tick's update
        if (cur_act) mix <= mix + mixprod;
        preg <= p_c;
      end
      bsv_pkg::ST_T_S1: begin
        if (sdone) begin
          g1t  <= g1prod[36:16];
          harg <= half + np_lo;
          if (!n2) begin
            g2t  <= '0;
            git  <= '0;
            inew <= '0;
          end
        end
      end
      bsv_pkg::ST_T_S2: begin
        if (sdone) begin
          g2t <= g2prod[36:16];
          if (!n3) begin
            git  <= '0;
            inew <= '0;
          end
        end
      end
      bsv_pkg::ST_T_DEN: begin
        if (sdone) den <= sres;
      end
      bsv_pkg::ST_T_NUM: begin
        // zero denominator takes the clamp value
        if (sdone && (den == '0)) bq <= $signed({2'b00, lim}) - 32'sd131072;
      end
      bsv_pkg::ST_T_DIV: begin
        if (ddone) bq <= bwide[31:0];
      end
      bsv_pkg::ST_T_STEP: stepprod <= bq * $signed({1'b0, cur.increment});
      bsv_pkg::ST_T_LEAK: leakprod <= cur.integrator * $signed({1'b0, leak});
      bsv_pkg::ST_T_ACC: begin
        if ((acc[49:47] == 3'b000) || (acc[49:47] == 3'b111)) begin
          inew <= acc[47:0];
        end else begin
          inew <= acc[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
      end
      bsv_pkg::ST_T_GI: git <= giprod[58:16];
      bsv_pkg::ST_T_VAL: begin
        if ((&vsum[44:23]) || !(|vsum[44:23])) begin
          vnew <= vsum[23:0];
        end else begin
          vnew <= vsum[44] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
        end
      end
      default: ;
    endcase
    if (out_load) begin
      silent_q <= ~|active;
      if ((&mix32[31:23]) || !(|mix32[31:23])) begin
        sample_q <= mix32[23:0];
      end else begin
        sample_q <= mix32[31] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
      end
    end
  end

  assign sample_out.valid      = out_valid;
  assign sample_out.sample     = sample_q;
  assign sample_out.all_silent = silent_q;

endmodule

`default_nettype wire
